// ----- rtl/rcf_pkg.sv -----
package rcf_pkg;

  localparam int PXW = 24;
  localparam int OUT_FIFO_DEPTH = 16;
  localparam logic [12:0] HEIGHT_MAX = 13'd4096;

  localparam logic [1:0] KIND_BOX     = 2'd0;
  localparam logic [1:0] KIND_GAUSS   = 2'd1;
  localparam logic [1:0] KIND_SOBEL   = 2'd2;
  localparam logic [1:0] KIND_PREWITT = 2'd3;

  localparam logic [2:0] CFG_KIND   = 3'd0;
  localparam logic [2:0] CFG_SIZE   = 3'd1;
  localparam logic [2:0] CFG_DIR    = 3'd2;
  localparam logic [2:0] CFG_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_HEIGHT = 3'd4;

  // {red, green, blue}
  typedef logic [PXW-1:0] pix_t;

  typedef struct packed {
    logic       live;
    logic       emit;
    logic       filt;
    logic [11:0] row;
    logic [10:0] col;
    pix_t       pix;
  } ctl_t;

  typedef struct packed {
    logic       valid;
    logic [11:0] row;
    logic [10:0] col;
    pix_t       pix;
  } res_t;

  localparam logic [7:0] G3 [3][3] = '{
    '{8'd1, 8'd2, 8'd1},
    '{8'd2, 8'd4, 8'd2},
    '{8'd1, 8'd2, 8'd1}
  };

  localparam logic [7:0] G5 [5][5] = '{
    '{8'd1, 8'd4,  8'd7,  8'd4,  8'd1},
    '{8'd4, 8'd16, 8'd26, 8'd16, 8'd4},
    '{8'd7, 8'd26, 8'd41, 8'd26, 8'd7},
    '{8'd4, 8'd16, 8'd26, 8'd16, 8'd4},
    '{8'd1, 8'd4,  8'd7,  8'd4,  8'd1}
  };

  localparam logic [7:0] G7 [7][7] = '{
    '{8'd0, 8'd0,  8'd0,   8'd5,   8'd0,   8'd0,  8'd0},
    '{8'd0, 8'd5,  8'd18,  8'd32,  8'd18,  8'd5,  8'd0},
    '{8'd0, 8'd18, 8'd64,  8'd100, 8'd64,  8'd18, 8'd0},
    '{8'd5, 8'd32, 8'd100, 8'd100, 8'd100, 8'd32, 8'd5},
    '{8'd0, 8'd18, 8'd64,  8'd100, 8'd64,  8'd18, 8'd0},
    '{8'd0, 8'd5,  8'd18,  8'd32,  8'd18,  8'd5,  8'd0},
    '{8'd0, 8'd0,  8'd0,   8'd5,   8'd0,   8'd0,  8'd0}
  };

  // [direction][dy][dx]
  localparam logic signed [2:0] SOBEL_K [2][3][3] = '{
    '{'{-3'sd1, 3'sd0, 3'sd1}, '{-3'sd2, 3'sd0, 3'sd2}, '{-3'sd1, 3'sd0, 3'sd1}},
    '{'{-3'sd1, -3'sd2, -3'sd1}, '{3'sd0, 3'sd0, 3'sd0}, '{3'sd1, 3'sd2, 3'sd1}}
  };

  localparam logic signed [2:0] PREWITT_K [2][3][3] = '{
    '{'{-3'sd1, 3'sd0, 3'sd1}, '{-3'sd1, 3'sd0, 3'sd1}, '{-3'sd1, 3'sd0, 3'sd1}},
    '{'{-3'sd1, -3'sd1, -3'sd1}, '{3'sd0, 3'sd0, 3'sd0}, '{3'sd1, 3'sd1, 3'sd1}}
  };

  // Weight for window tap at column age c, row age k (0 = newest).
  function automatic logic signed [8:0] rcf_weight(input logic [1:0] kind,
                                                   input logic [1:0] rad,
                                                   input logic dir,
                                                   input int c,
                                                   input int k);
    int n;
    int dy;
    int dx;
    logic signed [8:0] w;
    n = 2 * int'(rad) + 1;
    w = '0;
    if (c < n && k < n) begin
      dy = 2 * int'(rad) - k;
      dx = 2 * int'(rad) - c;
      case (kind)
        KIND_BOX: w = 9'sd1;
        KIND_GAUSS: begin
          case (rad)
            2'd1:    w = $signed({1'b0, G3[dy][dx]});
            2'd2:    w = $signed({1'b0, G5[dy][dx]});
            default: w = $signed({1'b0, G7[dy][dx]});
          endcase
        end
        KIND_SOBEL: w = 9'(SOBEL_K[dir][dy][dx]);
        default:    w = 9'(PREWITT_K[dir][dy][dx]);
      endcase
    end
    return w;
  endfunction

  // ceil(2^32 / divisor); exact for sums below 2^19
  function automatic logic [28:0] rcf_recip(input logic [1:0] kind, input logic [1:0] rad);
    logic [28:0] m;
    m = '0;
    if (kind == KIND_BOX) begin
      case (rad)
        2'd1:    m = 29'd477218589;
        2'd2:    m = 29'd171798692;
        default: m = 29'd87652394;
      endcase
    end else if (kind == KIND_GAUSS) begin
      case (rad)
        2'd1:    m = 29'd268435456;
        2'd2:    m = 29'd15732481;
        default: m = 29'd4021505;
      endcase
    end
    return m;
  endfunction

endpackage

// ----- rtl/rcf_line_ram.sv -----
module rcf_line_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 168
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] ra_addr,
  output logic [DW-1:0] ra_data,
  input  logic [AW-1:0] rb_addr,
  output logic [DW-1:0] rb_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- rtl/rcf_kernel.sv -----
module rcf_kernel #(
  parameter int SIDE = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    kind,
  input  logic [1:0]    rad,
  input  logic          dir,
  input  rcf_pkg::pix_t win [SIDE][SIDE],
  input  rcf_pkg::ctl_t ctl_in,
  output logic          push,
  output rcf_pkg::res_t res
);
  import rcf_pkg::*;

  logic signed [8:0]  wt_r [SIDE][SIDE];
  logic [28:0]        recip_r;
  logic               edge_r;
  logic signed [17:0] prod_r [3][SIDE][SIDE];
  logic signed [20:0] rsum_r [3][SIDE];
  logic signed [20:0] rsum_nxt [3][SIDE];
  logic signed [23:0] tot_r [3];
  logic signed [23:0] tot_nxt [3];
  logic [48:0]        quo_r [3];
  logic [7:0]         lo8_r [3];
  logic [7:0]         val [3];
  ctl_t               c1_r, c2_r, c3_r, c4_r;
  res_t               res_r, res_nxt;
  logic               push_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < SIDE; c++) begin
      for (int k = 0; k < SIDE; k++) begin
        wt_r[c][k] <= rcf_weight(kind, rad, dir, c, k);
      end
    end
    recip_r <= rcf_recip(kind, rad);
    edge_r  <= (kind == KIND_SOBEL) || (kind == KIND_PREWITT);
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < SIDE; c++) begin
        for (int k = 0; k < SIDE; k++) begin
          prod_r[ch][c][k] <= $signed({1'b0, win[c][k][(2-ch)*8 +: 8]}) * wt_r[c][k];
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < SIDE; c++) begin
        rsum_nxt[ch][c] = '0;
        for (int k = 0; k < SIDE; k++) begin
          rsum_nxt[ch][c] = rsum_nxt[ch][c] + 21'(prod_r[ch][c][k]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot_nxt[ch] = '0;
      for (int c = 0; c < SIDE; c++) begin
        tot_nxt[ch] = tot_nxt[ch] + 24'(rsum_r[ch][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    rsum_r <= rsum_nxt;
    tot_r  <= tot_nxt;
    for (int ch = 0; ch < 3; ch++) begin
      quo_r[ch] <= 49'(tot_r[ch][19:0]) * 49'(recip_r);
      lo8_r[ch] <= tot_r[ch][7:0];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      val[ch] = edge_r ? lo8_r[ch] : quo_r[ch][39:32];
    end
  end

  always_comb begin
    res_nxt = '0;
    if (c4_r.emit) begin
      res_nxt.valid = 1'b1;
      res_nxt.row   = c4_r.row;
      res_nxt.col   = c4_r.col;
      res_nxt.pix   = c4_r.filt ? {val[0], val[1], val[2]} : c4_r.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.live <= 1'b0;
      c2_r.live <= 1'b0;
      c3_r.live <= 1'b0;
      c4_r.live <= 1'b0;
      push_r    <= 1'b0;
    end else begin
      c1_r   <= ctl_in;
      c2_r   <= c1_r;
      c3_r   <= c2_r;
      c4_r   <= c3_r;
      push_r <= c4_r.live;
    end
    res_r <= res_nxt;
  end

  assign push = push_r;
  assign res  = res_r;

endmodule

// ----- rtl/rcf_out_fifo.sv -----
module rcf_out_fifo #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rcf_pkg::res_t din,
  input  logic          pop,
  output logic          nonempty,
  output rcf_pkg::res_t dout
);
  import rcf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  res_t            mem [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end

  assign nonempty = (cnt_r != '0);
  assign dout     = mem[rp_r];

endmodule

// ----- rtl/rgb_window_convolution_filter.sv -----
// Channel | Dir | Handshake         | Payload
// in_     | in  | tvalid / tready   | tdata: red, green, blue; tuser: cmd
// out_    | out | tvalid / tready   | tdata: row, col, red, green, blue; tuser: valid
// cfg_    | in  | we                | addr: register index; wdata: value
//
// One item per clock while in_tready is high; every item gives one result.
// The line store takes at most one column read-modify-write per item; that port sets the rate.
// After reset a sweep clears every line store entry; in_tready is low meanwhile.
// Up to 16 items may sit between input and output; past that in_tready drops.
// Output stalls are absorbed by the result queue; the pipeline itself never stops.
module rgb_window_convolution_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_row, out_col, red_out, green_out, blue_out, pad
  output logic        out_tuser,  // out_valid
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);
  import rcf_pkg::*;

  localparam int RING = 2 * MAX_RADIUS + 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int SW   = $clog2(RING);
  localparam int DW   = RING * PXW;
  localparam int PW   = $clog2(OUT_FIFO_DEPTH + 1);

  // configuration
  logic [1:0]  kind_r, size_r;
  logic        dir_r;
  logic [11:0] width_r;
  logic [12:0] height_r;

  // position state
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [12:0]   in_row_r, in_row_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  logic          clr_busy_r;
  logic [CW-1:0] clr_idx_r;
  logic [PW-1:0] pend_r;

  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [1:0]    rsel, rad;
  logic          accept, pop;

  logic          wrap0, wrap1, tail, ign, pre, over, emit, last, filt;
  logic [1:0]    bor;
  logic [WW-1:0] cdef;
  logic [CW-1:0] col0, col1;
  logic [12:0]   row0, row1, orow;
  logic [SW-1:0] slot0, slot1, oslot;
  logic [WW-1:0] col_inc, ocol_w;
  logic [WW:0]   ocol_far;
  logic [CW-1:0] ocol;
  logic [SW:0]   slot_tmp;
  logic [2:0]    dslot;

  // stage 1
  logic          p1_v_r, p1_adv_r, p1_wr_r;
  logic [CW-1:0] p1_col_r;
  logic [SW-1:0] p1_slot_r, p1_oslot_r;
  pix_t          p1_pix_r;
  ctl_t          p1_ctl_r;

  logic [DW-1:0] ra_data, rb_data, entry, merged;
  logic          fwd_v_r;
  logic [CW-1:0] fwd_col_r;
  logic [DW-1:0] fwd_data_r;
  pix_t          new_col [RING];
  logic [SW:0]   sidx_tmp;
  logic [SW-1:0] sidx;

  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  pix_t          win_r [RING][RING];
  ctl_t          p2_ctl_r;
  logic          k_push, fifo_nonempty;
  res_t          k_res, fifo_dout;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_BOX;
      size_r   <= 2'd1;
      dir_r    <= 1'b1;
      width_r  <= 12'd512;
      height_r <= 13'd512;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KIND:   kind_r   <= cfg_wdata[1:0];
        CFG_SIZE:   size_r   <= cfg_wdata[1:0];
        CFG_DIR:    dir_r    <= cfg_wdata[0];
        CFG_WIDTH:  width_r  <= cfg_wdata[11:0];
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = 13'd1;
    end else if (height_r > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = height_r;
    end
    rsel = (size_r > 2'd2) ? 2'd2 : size_r;
    rad  = (kind_r == KIND_BOX || kind_r == KIND_GAUSS) ? rsel + 2'd1 : 2'd1;
    if (int'(rad) > MAX_RADIUS) begin
      rad = 2'(MAX_RADIUS);
    end
  end

  assign in_tready = !clr_busy_r && (pend_r < PW'(OUT_FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;

  // input position and delayed output position
  always_comb begin
    wrap0 = (WW'(in_col_r) >= w_eff);
    col0  = wrap0 ? '0 : in_col_r;
    row0  = in_row_r + 13'(wrap0);
    slot0 = (wrap0 && slot_r == SW'(RING - 1)) ? '0 : slot_r + SW'(wrap0);
    tail  = (row0 >= h_eff);
    ign   = !tail && in_tuser;

    col_inc = WW'(col0) + WW'(1);
    wrap1   = (col_inc >= w_eff);
    col1    = wrap1 ? '0 : CW'(col_inc);
    row1    = row0 + 13'(wrap1);
    slot1   = (wrap1 && slot0 == SW'(RING - 1)) ? '0 : slot0 + SW'(wrap1);

    // rows borrowed when the delayed column reaches back past column 0
    cdef = WW'(rad) - WW'(col0);
    if (WW'(col0) >= WW'(rad)) begin
      bor = 2'd0;
    end else if (cdef <= w_eff) begin
      bor = 2'd1;
    end else if ((WW+1)'(cdef) <= {w_eff, 1'b0}) begin
      bor = 2'd2;
    end else begin
      bor = 2'd3;
    end
    pre  = (row0 < 13'(rad) + 13'(bor));
    orow = row0 - 13'(rad) - 13'(bor);
    case (bor)
      2'd0:    ocol_w = WW'(col0) - WW'(rad);
      2'd1:    ocol_w = WW'(col0) + w_eff - WW'(rad);
      2'd2:    ocol_w = WW'(col0) + {w_eff[WW-2:0], 1'b0} - WW'(rad);
      default: ocol_w = WW'(col0) + w_eff + {w_eff[WW-2:0], 1'b0} - WW'(rad);
    endcase
    ocol   = CW'(ocol_w);
    over   = !pre && (orow >= h_eff);
    emit   = !pre && !over;
    last   = emit && (orow == h_eff - 13'd1) && (ocol_w == w_eff - WW'(1));
    ocol_far = (WW+1)'(ocol_w) + (WW+1)'(rad);
    filt   = (orow >= 13'(rad)) && (orow + 13'(rad) < h_eff) &&
             (ocol_w >= WW'(rad)) && (ocol_far < (WW+1)'(w_eff));

    dslot    = 3'(rad) + 3'(bor);
    slot_tmp = (SW+1)'(slot0) + (SW+1)'(RING) - (SW+1)'(dslot);
    oslot    = (slot_tmp >= (SW+1)'(RING)) ? SW'(slot_tmp - (SW+1)'(RING)) : SW'(slot_tmp);

    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    slot_nxt   = slot_r;
    if (accept) begin
      if (ign) begin
        in_col_nxt = col0;
        in_row_nxt = row0;
        slot_nxt   = slot0;
      end else if (over || last) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        slot_nxt   = '0;
      end else begin
        in_col_nxt = col1;
        in_row_nxt = row1;
        slot_nxt   = slot1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      slot_r     <= '0;
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      pend_r     <= '0;
      p1_v_r     <= 1'b0;
      fwd_v_r    <= 1'b0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      slot_r   <= slot_nxt;
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + CW'(1);
        if (clr_idx_r == CW'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      pend_r  <= pend_r + PW'(accept) - PW'(pop);
      p1_v_r  <= accept;
      fwd_v_r <= p1_v_r && p1_wr_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_adv_r     <= !ign;
    p1_wr_r      <= !tail && !ign;
    p1_col_r     <= col0;
    p1_slot_r    <= slot0;
    p1_oslot_r   <= oslot;
    p1_pix_r     <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
    p1_ctl_r.live <= 1'b1;
    p1_ctl_r.emit <= emit && !ign;
    p1_ctl_r.filt <= filt;
    p1_ctl_r.row  <= orow[11:0];
    p1_ctl_r.col  <= 11'(ocol);
    p1_ctl_r.pix  <= '0;
    fwd_col_r    <= p1_col_r;
    fwd_data_r   <= merged;
  end

  // column read-modify-write, newest row first into the window
  always_comb begin
    entry  = (fwd_v_r && fwd_col_r == p1_col_r) ? fwd_data_r : ra_data;
    merged = entry;
    if (p1_wr_r) begin
      merged[p1_slot_r*PXW +: PXW] = p1_pix_r;
    end
    sidx_tmp = '0;
    sidx     = '0;
    for (int k = 0; k < RING; k++) begin
      sidx_tmp = (SW+1)'(p1_slot_r) + (SW+1)'(RING) - (SW+1)'(k);
      sidx = (sidx_tmp >= (SW+1)'(RING)) ? SW'(sidx_tmp - (SW+1)'(RING)) : SW'(sidx_tmp);
      new_col[k] = merged[sidx*PXW +: PXW];
    end
  end

  always_comb begin
    mem_we    = clr_busy_r || (p1_v_r && p1_wr_r);
    mem_waddr = clr_busy_r ? clr_idx_r : p1_col_r;
    mem_wdata = clr_busy_r ? '0 : merged;
  end

  rcf_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (DW)
  ) u_line_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (col0),
    .ra_data (ra_data),
    .rb_addr (ocol),
    .rb_data (rb_data)
  );

  always_ff @(posedge clk) begin
    if (p1_v_r && p1_adv_r) begin
      for (int c = RING - 1; c > 0; c--) begin
        win_r[c] <= win_r[c-1];
      end
      win_r[0] <= new_col;
    end
    p2_ctl_r.emit <= p1_ctl_r.emit;
    p2_ctl_r.filt <= p1_ctl_r.filt;
    p2_ctl_r.row  <= p1_ctl_r.row;
    p2_ctl_r.col  <= p1_ctl_r.col;
    p2_ctl_r.pix  <= rb_data[p1_oslot_r*PXW +: PXW];
    if (!rst_n) begin
      p2_ctl_r.live <= 1'b0;
    end else begin
      p2_ctl_r.live <= p1_v_r;
    end
  end

  rcf_kernel #(
    .SIDE (RING)
  ) u_kernel (
    .clk    (clk),
    .rst_n  (rst_n),
    .kind   (kind_r),
    .rad    (rad),
    .dir    (dir_r),
    .win    (win_r),
    .ctl_in (p2_ctl_r),
    .push   (k_push),
    .res    (k_res)
  );

  assign pop = fifo_nonempty && out_tready;

  rcf_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (k_push),
    .din      (k_res),
    .pop      (pop),
    .nonempty (fifo_nonempty),
    .dout     (fifo_dout)
  );

  assign out_tvalid = fifo_nonempty;
  assign out_tuser  = fifo_dout.valid;
  assign out_tdata  = {1'b0, fifo_dout.pix[7:0], fifo_dout.pix[15:8], fifo_dout.pix[23:16],
                       fifo_dout.col, fifo_dout.row};

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PW'(OUT_FIFO_DEPTH))
    else $error("items in flight exceed result queue depth");

  a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pend_r != '0))
    else $error("result offered with no item pending");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !p1_v_r)
    else $error("line store access during clear sweep");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rcf_pkg::*;

  typedef struct {
    bit       cmd;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    bit        valid;
    bit [11:0] row;
    bit [10:0] col;
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
  } pixel_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red_in, green_in, blue_in
  logic        in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // out_row, out_col, red_out, green_out, blue_out, pad
  logic        out_tuser;  // out_valid
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [12:0] cfg_wdata;

  rgb_window_convolution_filter u_top (.*);

  localparam int LINES = 7;
  localparam int MAXW = 2048;
  localparam int WDOG_LIMIT = 20000;

  logic [23:0] line_mem [LINES*MAXW];
  int unsigned col_pos, row_pos;
  int unsigned cur_kind, cur_size, cur_dir, cur_width, cur_height;

  pixel_in_t  pixel_q[$];
  pixel_out_t filtered_q[$];
  bit         failed;
  bit         in_acc, out_acc;
  int         in_gap, out_stall;
  bit         in_idle_on, out_idle_on;
  int         quiet_cycles;

  function automatic int unsigned mem_at(int unsigned row, int unsigned col);
    return (row % LINES) * MAXW + (col % MAXW);
  endfunction

  function automatic bit [7:0] filter_channel(int unsigned rad, int shift,
                                              int unsigned orow, int unsigned ocol);
    int unsigned n, acc, wsum, v, wt;
    int sacc;
    n = 2 * rad + 1;
    acc = 0;
    wsum = 0;
    sacc = 0;
    for (int dy = 0; dy < n; dy++) begin
      for (int dx = 0; dx < n; dx++) begin
        v = (line_mem[mem_at(orow - rad + dy, ocol - rad + dx)] >> shift) & 8'hFF;
        if (cur_kind == KIND_BOX) begin
          acc += v;
        end else if (cur_kind == KIND_GAUSS) begin
          if (rad == 1) wt = G3[dy][dx];
          else if (rad == 2) wt = G5[dy][dx];
          else wt = G7[dy][dx];
          acc += v * wt;
          wsum += wt;
        end else if (cur_kind == KIND_SOBEL) begin
          sacc += int'(v) * int'(SOBEL_K[cur_dir][dy][dx]);
        end else begin
          sacc += int'(v) * int'(PREWITT_K[cur_dir][dy][dx]);
        end
      end
    end
    if (cur_kind == KIND_BOX) return 8'(acc / (n * n));
    if (cur_kind == KIND_GAUSS) return 8'(wsum != 0 ? acc / wsum : 0);
    return 8'(sacc);
  endfunction

  function automatic int unsigned eff_width();
    if (cur_width == 0) return 1;
    if (cur_width > MAXW) return MAXW;
    return cur_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cur_height == 0) return 1;
    if (cur_height > 4096) return 4096;
    return cur_height;
  endfunction

  function automatic int unsigned eff_radius();
    if (cur_kind >= KIND_SOBEL) return 1;
    return (cur_size > 2 ? 2 : cur_size) + 1;
  endfunction

  function automatic pixel_out_t convolve_pixel(pixel_in_t it);
    pixel_out_t  res;
    int unsigned w, h, rad, lin_in, lat, lin, orow, ocol;
    bit          tail;
    logic [23:0] p;
    res = '{default: 0};
    w = eff_width();
    h = eff_height();
    rad = eff_radius();
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    tail = row_pos >= h;
    if (!tail && it.cmd) return res;
    if (!tail) line_mem[mem_at(row_pos, col_pos)] = {it.red, it.green, it.blue};
    lin_in = row_pos * w + col_pos;
    lat = rad * w + rad;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (lin_in < lat) return res;
    lin = lin_in - lat;
    if (lin >= w * h) begin
      col_pos = 0;
      row_pos = 0;
      return res;
    end
    orow = lin / w;
    ocol = lin % w;
    if (orow >= rad && orow + rad < h && ocol >= rad && ocol + rad < w) begin
      res.red = filter_channel(rad, 16, orow, ocol);
      res.green = filter_channel(rad, 8, orow, ocol);
      res.blue = filter_channel(rad, 0, orow, ocol);
    end else begin
      p = line_mem[mem_at(orow, ocol)];
      res.red = p[23:16];
      res.green = p[15:8];
      res.blue = p[7:0];
    end
    res.valid = 1;
    res.row = 12'(orow);
    res.col = 11'(ocol);
    if (lin == w * h - 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // monitor
  always @(posedge clk) begin
    pixel_in_t  it;
    pixel_out_t got, want;
    in_acc = rst_n && in_tvalid && in_tready;
    out_acc = rst_n && out_tvalid && out_tready;
    if (in_acc) begin
      it.cmd = in_tuser;
      it.red = in_tdata[7:0];
      it.green = in_tdata[15:8];
      it.blue = in_tdata[23:16];
      filtered_q.push_back(convolve_pixel(it));
    end
    if (out_acc) begin
      got.valid = out_tuser;
      got.row = out_tdata[11:0];
      got.col = out_tdata[22:12];
      got.red = out_tdata[30:23];
      got.green = out_tdata[38:31];
      got.blue = out_tdata[46:39];
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected item v=%0d r=%0d c=%0d rgb=%h%h%h", $time,
                 got.valid, got.row, got.col, got.red, got.green, got.blue);
        failed = 1;
      end else begin
        want = filtered_q.pop_front();
        if (got != want) begin
          $display("%0t: mismatch exp v=%0d r=%0d c=%0d rgb=%h%h%h", $time,
                   want.valid, want.row, want.col, want.red, want.green, want.blue);
          $display("%0t:          got v=%0d r=%0d c=%0d rgb=%h%h%h", $time,
                   got.valid, got.row, got.col, got.red, got.green, got.blue);
          failed = 1;
        end
      end
    end
    if (in_acc || out_acc || (pixel_q.size() == 0 && filtered_q.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    pixel_in_t it;
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (in_gap != 0 || pixel_q.size() == 0) begin
        in_tvalid <= 0;
        if (in_gap != 0) in_gap--;
      end else begin
        it = pixel_q.pop_front();
        in_tvalid <= 1;
        in_tuser <= it.cmd;
        in_tdata <= {it.blue, it.green, it.red};
        in_gap = in_idle_on ? $urandom_range(0, 12) : 0;
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) out_stall = out_idle_on ? $urandom_range(0, 12) : 0;
      else if (out_stall != 0) out_stall--;
      out_tready <= (out_stall == 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= 13'(val);
    case (idx)
      CFG_KIND: cur_kind = val & 3;
      CFG_SIZE: cur_size = val & 3;
      CFG_DIR: cur_dir = val & 1;
      CFG_WIDTH: cur_width = val & 12'hFFF;
      CFG_HEIGHT: cur_height = val & 13'h1FFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && !in_tvalid && filtered_q.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic bit [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_pixel(bit cmd, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    pixel_in_t it;
    it.cmd = cmd;
    it.red = r;
    it.green = g;
    it.blue = b;
    pixel_q.push_back(it);
  endfunction

  initial begin
    int sent, frame, pad, w, h;
    failed = 0;
    col_pos = 0;
    row_pos = 0;
    cur_kind = 0;
    cur_size = 1;
    cur_dir = 1;
    cur_width = 512;
    cur_height = 512;
    for (int i = 0; i < LINES * MAXW; i++) line_mem[i] = '0;
    in_gap = 0;
    out_stall = 0;
    in_idle_on = 0;
    out_idle_on = 0;
    quiet_cycles = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    out_tready = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: small image, extreme colors, padding inside the image
    write_reg(CFG_WIDTH, 8);
    write_reg(CFG_HEIGHT, 8);
    write_reg(CFG_SIZE, 0);
    for (int i = 0; i < 20; i++) begin
      if (i == 5) add_pixel(1, 8'hFF, 8'hFF, 8'hFF);
      else if (i[0]) add_pixel(0, 8'hFF, 8'hFF, 8'hFF);
      else add_pixel(0, 8'h00, 8'h00, 8'h00);
    end
    drain();

    sent = 0;
    while (sent < 1600) begin
      write_reg(CFG_KIND, $urandom_range(0, 3));
      write_reg(CFG_SIZE, $urandom_range(0, 3));
      write_reg(CFG_DIR, $urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: write_reg(CFG_WIDTH, 2048);
        1: write_reg(CFG_WIDTH, $urandom_range(0, 1) ? 0 : 4095);
        default: write_reg(CFG_WIDTH, $urandom_range(8, 13));
      endcase
      case ($urandom_range(0, 9))
        0: write_reg(CFG_HEIGHT, 4096);
        1: write_reg(CFG_HEIGHT, $urandom_range(0, 1) ? 0 : 8191);
        default: write_reg(CFG_HEIGHT, $urandom_range(8, 13));
      endcase
      in_idle_on = $urandom_range(0, 2) != 0;
      out_idle_on = $urandom_range(0, 2) != 0;
      w = eff_width();
      h = eff_height();
      frame = w * h;
      if (frame > 300) frame = 120;
      pad = eff_radius() * w + eff_radius();
      if (pad > 300) pad = 40;
      pad += $urandom_range(0, 3);
      for (int i = 0; i < frame; i++) begin
        if ($urandom_range(0, 19) == 0) add_pixel(1, rand_byte(), rand_byte(), rand_byte());
        add_pixel(0, rand_byte(), rand_byte(), rand_byte());
      end
      for (int i = 0; i < pad; i++)
        add_pixel($urandom_range(0, 9) != 0, rand_byte(), rand_byte(), rand_byte());
      sent += frame + pad;
      drain();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
